// File: src/crhp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crhp_pkg
// Shared types and constants of the chained record header parser.
// ----------------------------------------------------------------------------
package crhp_pkg;

    localparam int unsigned HDR_BYTES = 8;

    localparam logic [1:0] PH_HEADER  = 2'd0;
    localparam logic [1:0] PH_PAYLOAD = 2'd1;

    localparam logic [2:0] POS_SIZE_HI = 3'd0;
    localparam logic [2:0] POS_SIZE_LO = 3'd1;
    localparam logic [2:0] POS_TYPE_HI = 3'd6;
    localparam logic [2:0] POS_TYPE_LO = 3'd7;

    localparam logic ST_RECORD = 1'b0;
    localparam logic ST_SHORT  = 1'b1;

    localparam logic [7:0]  CHAIN_MAX = 8'hFF;
    localparam logic [11:0] HDR_LEN   = 12'(HDR_BYTES);

    typedef struct packed {
        logic [1:0]  phase;
        logic [2:0]  header_position;
        logic [15:0] size_word;
        logic [15:0] type_word;
        logic [11:0] payload_target;
        logic [11:0] payload_taken;
        logic [15:0] counter_word;
        logic [7:0]  chain_index;
    } t_state;

    typedef struct packed {
        logic        status;
        logic [7:0]  record_index;
        logic [15:0] raw_size_word;
        logic [11:0] record_length;
        logic [15:0] packet_type;
        logic [7:0]  packet_subtype;
        logic [11:0] payload_size;
        logic [15:0] peer_counter;
    } t_result;

endpackage

// File: src/crhp_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crhp_step
// Next-state and descriptor logic for one datagram byte.
// ----------------------------------------------------------------------------
module crhp_step (
    input  crhp_pkg::t_state  i_state,
    input  logic [7:0]        i_data_byte,
    input  logic              i_end_of_datagram,
    output crhp_pkg::t_state  o_state,
    output logic              o_emit,
    output crhp_pkg::t_result o_result
);

    crhp_pkg::t_state s;
    logic [11:0]      taken_inc;
    logic [11:0]      len;
    logic             emit_record;
    logic             emit_short;

    always_comb begin
        s           = i_state;
        taken_inc   = i_state.payload_taken + 12'd1;
        len         = 12'd0;
        emit_record = 1'b0;
        emit_short  = 1'b0;

        if (i_state.phase == crhp_pkg::PH_PAYLOAD) begin
            if (i_state.payload_taken == 12'd0) begin
                s.counter_word = {i_data_byte, 8'h00};
            end else if (i_state.payload_taken == 12'd1) begin
                s.counter_word = {i_state.counter_word[15:8], i_data_byte};
            end
            s.payload_taken = taken_inc;
            if (taken_inc >= i_state.payload_target || i_end_of_datagram) begin
                emit_record = 1'b1;
            end
        end else begin
            case (i_state.header_position)
                crhp_pkg::POS_SIZE_HI: s.size_word = {i_data_byte, 8'h00};
                crhp_pkg::POS_SIZE_LO: s.size_word = {i_state.size_word[15:8], i_data_byte};
                crhp_pkg::POS_TYPE_HI: s.type_word = {i_data_byte, 8'h00};
                crhp_pkg::POS_TYPE_LO: s.type_word = {i_state.type_word[15:8], i_data_byte};
                default: ;
            endcase
            if (i_state.header_position == crhp_pkg::POS_TYPE_LO) begin
                len              = s.size_word[11:0];
                s.payload_target = (len > crhp_pkg::HDR_LEN) ? len - crhp_pkg::HDR_LEN : 12'd0;
                s.payload_taken  = 12'd0;
                s.counter_word   = 16'd0;
                s.header_position = 3'd0;
                if (s.payload_target == 12'd0 || i_end_of_datagram) begin
                    emit_record = 1'b1;
                end else begin
                    s.phase = crhp_pkg::PH_PAYLOAD;
                end
            end else begin
                s.header_position = i_state.header_position + 3'd1;
                if (i_end_of_datagram && i_state.chain_index == 8'd0) begin
                    emit_short = 1'b1;
                end
            end
        end

        o_result = '0;
        if (emit_short) begin
            o_result.status = crhp_pkg::ST_SHORT;
        end else begin
            o_result.status         = crhp_pkg::ST_RECORD;
            o_result.record_index   = i_state.chain_index;
            o_result.raw_size_word  = s.size_word;
            o_result.record_length  = s.size_word[11:0];
            o_result.packet_type    = s.type_word;
            o_result.packet_subtype = s.type_word[15:8];
            o_result.payload_size   = s.payload_taken;
            o_result.peer_counter   = (s.payload_taken >= 12'd2) ?
                                      s.counter_word + 16'd1 : 16'd0;
        end

        if (emit_record) begin
            if (i_state.chain_index != crhp_pkg::CHAIN_MAX) begin
                s.chain_index = i_state.chain_index + 8'd1;
            end
            s.phase           = crhp_pkg::PH_HEADER;
            s.header_position = 3'd0;
        end
        if (i_end_of_datagram) begin
            s.phase           = crhp_pkg::PH_HEADER;
            s.header_position = 3'd0;
            s.chain_index     = 8'd0;
        end

        o_state = s;
        o_emit  = emit_record | emit_short;
    end

endmodule

// File: src/chained_record_header_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chained_record_header_parser
// Splits a byte-serial datagram into chained records and emits one
// descriptor per record, or a short-datagram error.
// ----------------------------------------------------------------------------
// Channel   Handshake             Payload
// input     i_valid / o_ready     i_data_byte, i_end_of_datagram
// output    o_valid / i_ready     o_status ... o_peer_counter (one descriptor)
//
// One byte is accepted per cycle unless the output stalls; a descriptor appears
// in the cycle after its completing byte, held in a single output register.
// The parser state is updated in the same cycle as the byte is accepted.
// A byte is accepted whenever the output register is empty or being drained.
// Synchronous active-low reset clears the parser to the first header.
// ----------------------------------------------------------------------------
module chained_record_header_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_datagram,
    output logic        o_valid,
    input  logic        i_ready,
    output logic        o_status,
    output logic [7:0]  o_record_index,
    output logic [15:0] o_raw_size_word,
    output logic [11:0] o_record_length,
    output logic [15:0] o_packet_type,
    output logic [7:0]  o_packet_subtype,
    output logic [11:0] o_payload_size,
    output logic [15:0] o_peer_counter
);

    crhp_pkg::t_state  r_state;
    crhp_pkg::t_state  n_state;
    crhp_pkg::t_result r_result;
    crhp_pkg::t_result n_result;
    logic              r_out_valid;
    logic              n_emit;
    logic              in_beat;

    assign o_ready = !r_out_valid || i_ready;
    assign in_beat = i_valid && o_ready;

    crhp_step u_step (
        .i_state           (r_state),
        .i_data_byte       (i_data_byte),
        .i_end_of_datagram (i_end_of_datagram),
        .o_state           (n_state),
        .o_emit            (n_emit),
        .o_result          (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_beat) begin
                r_state <= n_state;
            end
            if (in_beat && n_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && n_emit) begin
            r_result <= n_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_status         = r_result.status;
    assign o_record_index   = r_result.record_index;
    assign o_raw_size_word  = r_result.raw_size_word;
    assign o_record_length  = r_result.record_length;
    assign o_packet_type    = r_result.packet_type;
    assign o_packet_subtype = r_result.packet_subtype;
    assign o_payload_size   = r_result.payload_size;
    assign o_peer_counter   = r_result.peer_counter;

`ifndef SYNTHESIS
    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

    a_short_is_blank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> (o_record_index == 8'd0 && o_payload_size == 12'd0
                                   && o_peer_counter == 16'd0))
        else $error("short-datagram descriptor carries record data");

    a_counter_needs_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_payload_size < 12'd2) |-> (o_peer_counter == 16'd0))
        else $error("peer counter set without two payload bytes");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |-> !o_ready)
        else $error("byte accepted while descriptor is stalled");
`endif

endmodule
